// File: hw/rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
// No dependencies; imported by every module of the block.
package skt_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 4;
    localparam int STAT_W   = 3;
    localparam int OP_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    compare;
        logic    commit;
        logic    ins;
        logic    rmv;
        status_t code;
    } skt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            found;
        logic            full;
        logic            empty;
    } skt_stat_t;

endpackage

// File: hw/rtl/skt_ctrl.sv
// Sequencer for the sorted key table: handshakes and operation decisions.
// Depends on skt_pkg.
module skt_ctrl
    import skt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  skt_stat_t stat,
    output skt_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        cmd        = '{load: 1'b0, compare: 1'b0, commit: 1'b0,
                       ins: 1'b0, rmv: 1'b0, code: ST_NOT_FOUND};

        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    // take the next transaction while this one retires
                    in_stall   = 1'b0;
                    cmd.load   = in_valid;
                    state_next = in_valid ? S_CMP : S_IDLE;
                    unique case (op_t'(stat.op))
                        OP_SEARCH:
                            cmd.code = stat.found ? ST_OK : ST_NOT_FOUND;
                        OP_INSERT:
                        begin
                            if (stat.full)
                                cmd.code = ST_FULL;
                            else if (stat.found)
                                cmd.code = ST_DUPLICATE;
                            else
                            begin
                                cmd.code = ST_OK;
                                cmd.ins  = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (stat.empty)
                                cmd.code = ST_EMPTY;
                            else if (stat.found)
                            begin
                                cmd.code = ST_OK;
                                cmd.rmv  = 1'b1;
                            end
                            else
                                cmd.code = ST_NOT_FOUND;
                        end
                        default:
                            cmd.code = ST_NOT_FOUND;
                    endcase
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

endmodule

// File: hw/rtl/skt_datapath.sv
// Key cell row, parallel comparators, shift network and result register.
// Depends on skt_pkg.
module skt_datapath
    import skt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [OP_W-1:0]         op,
    input  logic signed [KEY_W-1:0] key,
    input  skt_cmd_t                cmd,
    output skt_stat_t               stat,
    output logic [STAT_W-1:0]       status,
    output logic [POS_W-1:0]        position,
    output logic [CNT_W-1:0]        fill
);

    logic [OP_W-1:0]         op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] store_reg  [CAPACITY];
    logic signed [KEY_W-1:0] store_next [CAPACITY];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CAPACITY-1:0]     lt_reg, lt_next;
    logic [CAPACITY-1:0]     eq_reg, eq_next;
    logic [CAPACITY-1:0]     edge_bits;
    logic [CNT_W-1:0]        lbound;
    logic [STAT_W-1:0]       status_reg;
    logic [POS_W-1:0]        position_reg;
    logic [CNT_W-1:0]        fill_reg;

    // capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            key_reg <= key;
        end
    end

    // one comparator per cell; only held cells take part
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lt_next[i] = (CNT_W'(i) < count_reg) && (store_reg[i] < key_reg);
            eq_next[i] = (CNT_W'(i) < count_reg) && (store_reg[i] == key_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    // lt_reg is a prefix of ones; its length is the insertion point
    always_comb
    begin
        lbound = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            edge_bits[i] = lt_reg[i] && ((i == CAPACITY - 1) ||
                           !lt_reg[(i < CAPACITY - 1) ? i + 1 : i]);
            lbound = lbound | (edge_bits[i] ? CNT_W'(i + 1) : '0);
        end
    end

    assign stat.op    = op_reg;
    assign stat.found = |eq_reg;
    assign stat.full  = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty = (count_reg == '0);

    // open a gap or close one
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            store_next[i] = store_reg[i];
            if (cmd.commit && cmd.ins)
            begin
                if (CNT_W'(i) == lbound)
                    store_next[i] = key_reg;
                else if (i > 0 && CNT_W'(i) > lbound)
                    store_next[i] = store_reg[(i > 0) ? i - 1 : 0];
            end
            else if (cmd.commit && cmd.rmv)
            begin
                if (i < CAPACITY - 1 && CNT_W'(i) >= lbound)
                    store_next[i] = store_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            store_reg[i] <= store_next[i];
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.commit && cmd.ins)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.commit && cmd.rmv)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg   <= cmd.code;
            position_reg <= (cmd.code == ST_OK) ? lbound[POS_W-1:0] : '0;
            fill_reg     <= count_next;
        end
    end

    assign status   = status_reg;
    assign position = position_reg;
    assign fill     = fill_reg;

endmodule

// File: hw/rtl/sorted_key_table_unit.sv
// An accepted transaction passes the compare stage of the 16-cell comparator row, then the
// shift/commit stage, which waits while a stalled result is held in the output register.
// A new transaction is taken only when idle or while the previous one commits.
// A finished result waits in the output register while the next transaction is taken.
// Reset clears the fill count and the handshake state; key cells hold whatever they held.
// Depends on skt_pkg, skt_ctrl and skt_datapath.
module sorted_key_table_unit
    import skt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // request channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [OP_W-1:0]         op,
    input  logic signed [KEY_W-1:0] key,
    // result channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STAT_W-1:0]       status,
    output logic [POS_W-1:0]        position,
    output logic [CNT_W-1:0]        fill
);

    skt_cmd_t  cmd;
    skt_stat_t stat;

    // Controller: walks each transaction through compare and commit, and
    // decides the outcome from the found/full/empty flags.
    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: the sorted row of key cells with a comparator per cell;
    // insert shifts the larger keys up, remove shifts later keys down.
    skt_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .key      (key),
        .cmd      (cmd),
        .stat     (stat),
        .status   (status),
        .position (position),
        .fill     (fill)
    );

endmodule

// File: hw/rtl/skt_checker.sv
// Port-level checks for sorted_key_table_unit, attached by bind.
// Depends on skt_pkg.
module skt_checker
    import skt_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic [OP_W-1:0]         op,
    input logic signed [KEY_W-1:0] key,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [STAT_W-1:0]       status,
    input logic [POS_W-1:0]        position,
    input logic [CNT_W-1:0]        fill
);

    // fill never exceeds capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fill <= CNT_W'(CAPACITY))
        else $error("fill above capacity");

    // failed operations report position zero
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> position == '0)
        else $error("position set on failed operation");

    // full and empty codes agree with the fill count
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != ST_FULL || fill == CNT_W'(CAPACITY))
                   && (status != ST_EMPTY || fill == '0))
        else $error("status disagrees with fill");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
                                   && $stable(position) && $stable(fill))
        else $error("stalled result changed");

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (.*);
